[rtl/core/fat12w_pkg.sv]
// Shared types and constants for the FAT12 cluster chain walker.
package fat12w_pkg;

   // Action codes carried on the request channel
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_WALK  = 2'd2;

   // First cluster value that ends a chain
   localparam logic [11:0] CHAIN_END = 12'hff0;
   localparam logic [7:0]  LOW_NIB   = 8'h0f;
   localparam logic [7:0]  HIGH_NIB  = 8'hf0;

   localparam int unsigned ADDR_W  = 13;
   localparam int unsigned DATA_W  = 8;
   localparam int unsigned CLUS_W  = 12;
   localparam int unsigned COUNT_W = 13;

   // Controller to datapath
   typedef struct packed {
      logic load;      // take the accepted item
      logic rd_hi;     // read address selects the second entry byte
      logic cap_lo;    // capture the first entry byte
      logic step;      // unpack the entry into the current cluster
      logic set_flag;  // length guard hit
      logic out_load;  // load the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_write;
      logic is_read;
      logic is_walk;
      logic at_end;    // current cluster is a terminator
      logic at_max;    // visit count reached the guard
   } status_type;

endpackage

[rtl/core/fat12w_if.sv]
// Request and response channel interfaces.
interface fat12w_req_if import fat12w_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          action;
   logic [ADDR_W-1:0]   byte_addr;
   logic [DATA_W-1:0]   byte_data;
   logic [CLUS_W-1:0]   start_cluster;

   modport source (output valid, action, byte_addr, byte_data, start_cluster, input ready);
   modport sink   (input valid, action, byte_addr, byte_data, start_cluster, output ready);
endinterface

interface fat12w_rsp_if import fat12w_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CLUS_W-1:0]   entry_value;
   logic [COUNT_W-1:0]  chain_length;
   logic                loop_flag;

   modport source (output valid, entry_value, chain_length, loop_flag, input ready);
   modport sink   (input valid, entry_value, chain_length, loop_flag, output ready);
endinterface

[rtl/core/fat12_cluster_chain_walker.sv]
// Top level of the FAT12 cluster chain walker.
//
//  channel | dir | handshake           | payload
//  req_ch  | in  | valid/ready         | action, byte_addr, byte_data, start_cluster
//  rsp_ch  | out | valid/ready         | entry_value, chain_length, loop_flag
//
// One item at a time. A write passes through check and done; an entry read adds two
// reads of the single table read port; a walk adds a check and two reads per link.
// The block returns to idle before the next item is taken.
// The result register frees the block for the next item while a result waits.
// Reset clears control and chain registers; table contents stay undefined until written.
// A stalled response holds the block in its final state until the result moves out.
module fat12_cluster_chain_walker import fat12w_pkg::*; #(
   parameter int unsigned TABLE_BYTES = 8192,
   parameter int unsigned MAX_CHAIN   = 4096
) (
   input  logic          clock,
   input  logic          reset,
   fat12w_req_if.sink    req_ch,
   fat12w_rsp_if.source  rsp_ch
);

   cmd_type    cmd;
   status_type status;

   fat12w_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fat12w_dp #(
      .TABLE_BYTES (TABLE_BYTES),
      .MAX_CHAIN   (MAX_CHAIN)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .action        (req_ch.action),
      .byte_addr     (req_ch.byte_addr),
      .byte_data     (req_ch.byte_data),
      .start_cluster (req_ch.start_cluster),
      .entry_value   (rsp_ch.entry_value),
      .chain_length  (rsp_ch.chain_length),
      .loop_flag     (rsp_ch.loop_flag)
   );

   // guard trips only at the full length
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.loop_flag |-> rsp_ch.chain_length == COUNT_W'(MAX_CHAIN))
      else $error("loop flag without full chain length");

   // a walk that ended normally stopped on a terminator
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.loop_flag && rsp_ch.chain_length != '0
      |-> rsp_ch.entry_value >= CHAIN_END)
      else $error("walk ended on a non-terminator");

   // an accepted item keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while busy");

endmodule

[rtl/core/fat12w_ctrl.sv]
// Sequencing state machine for writes, entry reads and chain walks.
module fat12w_ctrl import fat12w_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RD_A,
      ST_RD_B,
      ST_RD_C,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd          = '0;
      cmd.load     = accept;
      cmd.rd_hi    = (state_ff == ST_RD_B);
      cmd.cap_lo   = (state_ff == ST_RD_B);
      cmd.step     = (state_ff == ST_RD_C);
      cmd.set_flag = (state_ff == ST_CHECK) && !status.at_end && status.at_max;
      cmd.out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  // status reflects the item only from the next cycle: decode in ST_CHECK
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (status.is_read) begin
                  state_ff <= ST_RD_A;
               end else if (!status.is_walk) begin
                  state_ff <= ST_DONE;
               end else if (status.at_end || status.at_max) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_RD_A;
               end
            end
            ST_RD_A: state_ff <= ST_RD_B;
            ST_RD_B: state_ff <= ST_RD_C;
            ST_RD_C: begin
               state_ff <= status.is_walk ? ST_CHECK : ST_DONE;
            end
            ST_DONE: begin
               if (cmd.out_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[rtl/core/fat12w_dp.sv]
// Table store, entry unpacking, chain registers and result register.
module fat12w_dp import fat12w_pkg::*; #(
   parameter int unsigned TABLE_BYTES = 8192,
   parameter int unsigned MAX_CHAIN   = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [1:0]         action,
   input  logic [ADDR_W-1:0]  byte_addr,
   input  logic [DATA_W-1:0]  byte_data,
   input  logic [CLUS_W-1:0]  start_cluster,
   output logic [CLUS_W-1:0]  entry_value,
   output logic [COUNT_W-1:0] chain_length,
   output logic               loop_flag
);

   localparam int unsigned MemAw = $clog2(TABLE_BYTES);
   localparam logic [ADDR_W:0]    TableLimit = (ADDR_W+1)'(TABLE_BYTES);
   localparam logic [COUNT_W-1:0] ChainLimit = COUNT_W'(MAX_CHAIN);

   logic [DATA_W-1:0] mem [TABLE_BYTES];

   logic [1:0]         act_ff;
   logic [CLUS_W-1:0]  cl_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               flag_ff;
   logic [DATA_W-1:0]  lo_ff;
   logic [DATA_W-1:0]  rdata_ff;
   logic               rok_ff;
   logic [CLUS_W-1:0]  out_value_ff;
   logic [COUNT_W-1:0] out_length_ff;
   logic               out_flag_ff;

   logic [ADDR_W-1:0]  base;
   logic [ADDR_W-1:0]  rd_addr;
   logic               rd_ok;
   logic               wr_en;
   logic [DATA_W-1:0]  rbyte;
   logic [CLUS_W-1:0]  entry;

   // entry pair base = 3 * (cluster / 2)
   assign base    = {1'b0, cl_ff[CLUS_W-1:1], 1'b0} + {2'b00, cl_ff[CLUS_W-1:1]};
   assign rd_addr = base + ADDR_W'(cl_ff[0]) + ADDR_W'(cmd.rd_hi);
   assign rd_ok   = {1'b0, rd_addr} < TableLimit;
   assign wr_en   = cmd.load && (action == ACT_WRITE) && ({1'b0, byte_addr} < TableLimit);
   assign rbyte   = rok_ff ? rdata_ff : '0;

   // even: low nibble of middle byte over first byte; odd: third byte over high nibble
   always_comb begin
      if (!cl_ff[0]) begin
         entry = {rbyte[3:0] & LOW_NIB[3:0], lo_ff};
      end else begin
         entry = {rbyte, 4'((lo_ff & HIGH_NIB) >> 4)};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[byte_addr[MemAw-1:0]] <= byte_data;
      end
      rdata_ff <= mem[rd_addr[MemAw-1:0]];
      rok_ff   <= rd_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= ACT_WRITE;
         cl_ff    <= '0;
         count_ff <= '0;
         flag_ff  <= 1'b0;
      end else if (cmd.load) begin
         act_ff   <= action;
         cl_ff    <= start_cluster;
         count_ff <= '0;
         flag_ff  <= 1'b0;
      end else begin
         if (cmd.step) begin
            cl_ff <= entry;
            if (act_ff == ACT_WALK) begin
               count_ff <= count_ff + 1'b1;
            end
         end
         if (cmd.set_flag) begin
            flag_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_lo) begin
         lo_ff <= rbyte;
      end
      if (cmd.out_load) begin
         out_value_ff  <= (act_ff == ACT_READ || act_ff == ACT_WALK) ? cl_ff : '0;
         out_length_ff <= (act_ff == ACT_WALK) ? count_ff : '0;
         out_flag_ff   <= (act_ff == ACT_WALK) && flag_ff;
      end
   end

   assign status.is_write = (act_ff == ACT_WRITE);
   assign status.is_read  = (act_ff == ACT_READ);
   assign status.is_walk  = (act_ff == ACT_WALK);
   assign status.at_end   = (cl_ff >= CHAIN_END);
   assign status.at_max   = (count_ff >= ChainLimit);

   assign entry_value  = out_value_ff;
   assign chain_length = out_length_ff;
   assign loop_flag    = out_flag_ff;

endmodule
